>>> src/u8dec_pkg.sv
// Package for the UTF-8 validating decoder.
// Holds status codes, byte masks, code point floors and the result struct.
// No dependencies.
package u8dec_pkg;

  localparam int unsigned CP_W = 21;

  typedef logic [1:0]      status_t;
  typedef logic [CP_W-1:0] code_point_t;

  // result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_LEAD = 2'd1;
  localparam status_t ST_MISSING  = 2'd2;
  localparam status_t ST_OVERLONG = 2'd3;

  // byte classification masks and patterns
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  // payload bits carried by each byte kind
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_BITS = 8'h07;
  localparam logic [7:0] CONT_BITS  = 8'h3F;

  // sequence length minus one
  localparam logic [1:0] LEN_ONE   = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR  = 2'd3;

  // smallest legal value for each multi-byte length
  localparam code_point_t FLOOR_TWO   = 21'h00080;
  localparam code_point_t FLOOR_THREE = 21'h00800;
  localparam code_point_t FLOOR_FOUR  = 21'h10000;

  // one decoded result, with a flag saying whether the step produced it
  typedef struct packed {
    logic        emit;
    code_point_t code_point;
    status_t     status;
    logic        end_of_string;
  } result_t;

endpackage

>>> src/u8dec_if.sv
// Channel interfaces for the UTF-8 validating decoder.
// Byte channel in, result channel out; depends on u8dec_pkg.
interface u8dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8dec_result_if;
  logic                 valid;
  logic                 ready;
  u8dec_pkg::code_point_t code_point;
  u8dec_pkg::status_t   status;
  logic                 end_of_string;

  modport source (output valid, output code_point, output status,
                  output end_of_string, input ready);
  modport sink   (input valid, input code_point, input status,
                  input end_of_string, output ready);
endinterface

>>> src/utf8_validating_decoder_unit.sv
// UTF-8 validating decoder, top level.
// Ties input register, decode step and result register; uses u8dec_pkg and u8dec_if.

// The block takes one byte beat per clock unless the result side stalls, and
// gives at most one result beat per byte: a code point when a sequence
// completes with status ok, or one error status (bad lead, missing
// continuation or truncation, overlong) after which the rest of that string
// is dropped up to its flagged last byte. Throughput is one byte per cycle
// when not stalled, with no dead cycles between strings. A byte accepted into
// the input register is decoded combinationally on its way to the result
// register. A stalled result holds the decode step, and ready drops once the
// input register holds a byte.
module utf8_validating_decoder_unit (
  input  logic           clk,
  input  logic           rst,
  u8dec_byte_if.sink     in_bytes,
  u8dec_result_if.source out_results
);

  logic               held_valid;
  logic [7:0]         held_byte;
  logic               held_last;
  logic               can_take;
  logic               advance;
  u8dec_pkg::result_t result;

  // a held byte moves on when the result register has room
  assign advance = held_valid && can_take;

  u8dec_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_bytes   (in_bytes),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  u8dec_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (held_byte),
    .last_byte (held_last),
    .result    (result)
  );

  u8dec_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .result      (result),
    .can_take    (can_take),
    .out_results (out_results)
  );

endmodule

>>> src/u8dec_in_reg.sv
// Input register of the UTF-8 decoder.
// Captures one byte beat and holds it until the decode step takes it; uses u8dec_if.
module u8dec_in_reg (
  input  logic              clk,
  input  logic              rst,
  u8dec_byte_if.sink        in_bytes,
  input  logic              advance,
  output logic              held_valid,
  output logic [7:0]        held_byte,
  output logic              held_last
);

  logic accept;

  // room when empty or when the held byte leaves this cycle
  assign in_bytes.ready = !held_valid || advance;
  assign accept         = in_bytes.valid && in_bytes.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= in_bytes.data_byte;
      held_last <= in_bytes.last_byte;
    end
  end

endmodule

>>> src/u8dec_core.sv
// Decode step of the UTF-8 decoder: sequence state and per-byte validation.
// Uses u8dec_pkg for masks, status codes and the result struct.
module u8dec_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output u8dec_pkg::result_t  result
);

  logic [1:0]             bytes_left, bytes_left_next;
  logic [1:0]             sequence_length, sequence_length_next;
  u8dec_pkg::code_point_t code_accumulator, code_accumulator_next;
  logic                   rejecting, rejecting_next;

  u8dec_pkg::code_point_t acc_shifted;
  logic [1:0]             left_dec;
  u8dec_pkg::code_point_t floor_val;
  logic                   is_cont;

  assign acc_shifted = {code_accumulator[u8dec_pkg::CP_W-7:0],
                        data_byte[5:0] & u8dec_pkg::CONT_BITS[5:0]};
  assign left_dec    = bytes_left - 2'd1;
  assign is_cont     = (data_byte & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_PAT;

  // overlong floor for the current sequence length
  always_comb begin
    case (sequence_length)
      u8dec_pkg::LEN_TWO:   floor_val = u8dec_pkg::FLOOR_TWO;
      u8dec_pkg::LEN_THREE: floor_val = u8dec_pkg::FLOOR_THREE;
      default:              floor_val = u8dec_pkg::FLOOR_FOUR;
    endcase
  end

  // per-byte decision
  always_comb begin
    logic fail;
    logic [1:0] fail_status;
    fail                  = 1'b0;
    fail_status           = u8dec_pkg::ST_OK;
    bytes_left_next       = bytes_left;
    sequence_length_next  = sequence_length;
    code_accumulator_next = code_accumulator;
    rejecting_next        = rejecting;
    result                = '0;

    if (rejecting) begin
      // drop bytes until the end of the string
      if (last_byte) begin
        bytes_left_next       = 2'd0;
        sequence_length_next  = u8dec_pkg::LEN_ONE;
        code_accumulator_next = '0;
        rejecting_next        = 1'b0;
      end
    end else if (bytes_left == 2'd0) begin
      // expecting a lead byte
      if ((data_byte & u8dec_pkg::ASCII_MASK) == 8'h00) begin
        result.emit          = 1'b1;
        result.code_point    = {13'd0, data_byte};
        result.status        = u8dec_pkg::ST_OK;
        result.end_of_string = last_byte;
      end else begin
        if ((data_byte & u8dec_pkg::LEAD2_MASK) == u8dec_pkg::LEAD2_PAT) begin
          sequence_length_next  = u8dec_pkg::LEN_TWO;
          bytes_left_next       = u8dec_pkg::LEN_TWO;
          code_accumulator_next = {13'd0, data_byte & u8dec_pkg::LEAD2_BITS};
        end else if ((data_byte & u8dec_pkg::LEAD3_MASK) == u8dec_pkg::LEAD3_PAT) begin
          sequence_length_next  = u8dec_pkg::LEN_THREE;
          bytes_left_next       = u8dec_pkg::LEN_THREE;
          code_accumulator_next = {13'd0, data_byte & u8dec_pkg::LEAD3_BITS};
        end else if ((data_byte & u8dec_pkg::LEAD4_MASK) == u8dec_pkg::LEAD4_PAT) begin
          sequence_length_next  = u8dec_pkg::LEN_FOUR;
          bytes_left_next       = u8dec_pkg::LEN_FOUR;
          code_accumulator_next = {13'd0, data_byte & u8dec_pkg::LEAD4_BITS};
        end else begin
          fail        = 1'b1;
          fail_status = u8dec_pkg::ST_BAD_LEAD;
        end
        if (!fail && last_byte) begin
          fail        = 1'b1;
          fail_status = u8dec_pkg::ST_MISSING;
        end
      end
    end else if (!is_cont) begin
      // lead or ascii byte inside a sequence
      fail        = 1'b1;
      fail_status = u8dec_pkg::ST_MISSING;
    end else begin
      // good continuation byte
      code_accumulator_next = acc_shifted;
      bytes_left_next       = left_dec;
      if (left_dec != 2'd0) begin
        if (last_byte) begin
          fail        = 1'b1;
          fail_status = u8dec_pkg::ST_MISSING;
        end
      end else if (acc_shifted < floor_val) begin
        fail        = 1'b1;
        fail_status = u8dec_pkg::ST_OVERLONG;
      end else begin
        result.emit           = 1'b1;
        result.code_point     = acc_shifted;
        result.status         = u8dec_pkg::ST_OK;
        result.end_of_string  = last_byte;
        sequence_length_next  = u8dec_pkg::LEN_ONE;
        code_accumulator_next = '0;
      end
    end

    // error: clear the sequence, report once, drop the rest of the string
    if (fail) begin
      bytes_left_next       = 2'd0;
      sequence_length_next  = u8dec_pkg::LEN_ONE;
      code_accumulator_next = '0;
      rejecting_next        = !last_byte;
      result.emit           = 1'b1;
      result.code_point     = '0;
      result.status         = fail_status;
      result.end_of_string  = 1'b1;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left       <= 2'd0;
      sequence_length  <= u8dec_pkg::LEN_ONE;
      code_accumulator <= '0;
      rejecting        <= 1'b0;
    end else if (advance) begin
      bytes_left       <= bytes_left_next;
      sequence_length  <= sequence_length_next;
      code_accumulator <= code_accumulator_next;
      rejecting        <= rejecting_next;
    end
  end

endmodule

>>> src/u8dec_out_reg.sv
// Result register of the UTF-8 decoder.
// Holds one result beat until the sink takes it; uses u8dec_pkg and u8dec_if.
module u8dec_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  u8dec_pkg::result_t result,
  output logic               can_take,
  u8dec_result_if.source     out_results
);

  logic load;

  assign can_take = !out_results.valid || out_results.ready;
  assign load     = advance && result.emit;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_results.valid <= 1'b0;
    end else if (load) begin
      out_results.valid <= 1'b1;
    end else if (out_results.ready) begin
      out_results.valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_results.code_point    <= result.code_point;
      out_results.status        <= result.status;
      out_results.end_of_string <= result.end_of_string;
    end
  end

endmodule
